FILE: rtl/core/cace_pkg.sv
// Shared types and constants for the artifact colour expander.
package cace_pkg;

    // Two-bit pair codes as they arrive in the source byte
    typedef enum logic [1:0] {
        CodeBlack  = 2'b00,
        CodeBlue   = 2'b01,
        CodeOrange = 2'b10,
        CodeWhite  = 2'b11
    } pair_code_t;

    localparam int PixelWidth = 24;

    localparam logic [PixelWidth-1:0] ColorBlack  = 24'h000000;
    localparam logic [PixelWidth-1:0] ColorBlue   = 24'h0000FF;
    localparam logic [PixelWidth-1:0] ColorOrange = 24'hFFA500;
    localparam logic [PixelWidth-1:0] ColorWhite  = 24'hFFFFFF;

    // Up to five codes in flight for one byte: held pair plus four new pairs
    localparam int SlotCount = 5;

    // One pair handed from the item stage to the pixel stage
    typedef struct packed {
        pair_code_t code;
        pair_code_t right_code;
        logic       has_right;
        logic       row_done;
        logic       last;
    } pair_t;

endpackage

FILE: rtl/core/cace_in_if.sv
// Input channel: one source byte with its row-end flag per transfer.
interface cace_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       row_end;

    modport source (output valid, output source_byte, output row_end, input ready);
    modport sink (input valid, input source_byte, input row_end, output ready);
endinterface

FILE: rtl/core/cace_out_if.sv
// Output channel: one pixel pair per transfer.
interface cace_out_if;
    logic                          valid;
    logic                          ready;
    logic [cace_pkg::PixelWidth-1:0] left_pixel;
    logic [cace_pkg::PixelWidth-1:0] right_pixel;
    logic                          row_done;
    logic                          last;

    modport source (output valid, output left_pixel, output right_pixel,
                    output row_done, output last, input ready);
    modport sink (input valid, input left_pixel, input right_pixel,
                  input row_done, input last, output ready);
endinterface

FILE: rtl/core/crt_artifact_color_expander.sv
// Top level of the artifact colour expander.
//
// Usage:
//   in_ch  carries one framebuffer byte (four 2-bit pair codes, MSB pair
//          first) with a row_end flag; a transfer is valid and ready high.
//   out_ch carries one pixel pair per transfer: left and right 24-bit RGB,
//          row_done on the last pair of a row, last on the final pair that
//          a byte produces.
//   cfg_write_en / cfg_write_data write palette_swap (blue and orange
//          exchanged when set); write only while the block is idle.
// A byte's pairs pass the code queue, then the result register, to out_ch.
//   Pairs leave at one per cycle while the receiver is ready, set by the
//   single pixel colouring stage: a byte gives 3 pairs at the start of a
//   row, 4 in the middle, one more at a row end, since one pair is held
//   back until its right neighbour arrives. The next byte is taken in the
//   cycle its predecessor's final pair moves into the result register.
// Reset clears the held pair, the left neighbour and palette_swap.
// When the receiver stalls the result register holds and the input side
//   stops after the byte in hand; nothing is lost or repeated.
module crt_artifact_color_expander (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write_en,
    input  logic         cfg_write_data,
    cace_in_if.sink      in_ch,
    cace_out_if.source   out_ch
);

    logic              pair_valid;
    logic              pair_ready;
    cace_pkg::pair_t   pair;

    // Byte unpacking and pair sequencing
    cace_item_stage u_item_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair       (pair)
    );

    // Colouring and result register
    cace_pixel_stage u_pixel_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .pair_valid     (pair_valid),
        .pair_ready     (pair_ready),
        .pair           (pair),
        .out_ch         (out_ch)
    );

endmodule

FILE: rtl/core/cace_item_stage.sv
// Item stage: takes bytes, keeps the held pair, issues one pair a cycle when ready.
module cace_item_stage (
    input  logic               clk,
    input  logic               rst_n,
    cace_in_if.sink            in_ch,
    output logic               pair_valid,
    input  logic               pair_ready,
    output cace_pkg::pair_t    pair
);

    logic                   busy_reg, busy_next;
    logic [2:0]             ncodes_reg, ncodes_next;
    logic [2:0]             emits_left_reg, emits_left_next;
    logic                   row_end_reg, row_end_next;
    cace_pkg::pair_code_t   pending_code_reg, pending_code_next;
    logic                   pending_valid_reg, pending_valid_next;
    cace_pkg::pair_code_t   codes_reg [cace_pkg::SlotCount];
    cace_pkg::pair_code_t   codes_next [cace_pkg::SlotCount];
    cace_pkg::pair_code_t   new_codes [4];
    logic                   accept;
    logic                   pair_fire;
    logic                   final_pair;

    // Split the byte into pair codes, most significant pair first
    assign new_codes[0] = cace_pkg::pair_code_t'(in_ch.source_byte[7:6]);
    assign new_codes[1] = cace_pkg::pair_code_t'(in_ch.source_byte[5:4]);
    assign new_codes[2] = cace_pkg::pair_code_t'(in_ch.source_byte[3:2]);
    assign new_codes[3] = cace_pkg::pair_code_t'(in_ch.source_byte[1:0]);

    // Take a new byte when idle or as the current byte's final pair leaves
    assign final_pair  = (emits_left_reg == 3'd1);
    assign in_ch.ready = !busy_reg || (pair_ready && final_pair);
    assign accept      = in_ch.valid && in_ch.ready;
    assign pair_fire   = busy_reg && pair_ready;

    // Present the head code with its right neighbour
    assign pair_valid      = busy_reg;
    assign pair.code       = codes_reg[0];
    assign pair.right_code = codes_reg[1];
    assign pair.has_right  = (ncodes_reg >= 3'd2);
    assign pair.row_done   = row_end_reg && (ncodes_reg == 3'd1);
    assign pair.last       = final_pair;

    // Advance the code queue, load a new byte, update the held pair
    always_comb
    begin
        busy_next          = busy_reg;
        ncodes_next        = ncodes_reg;
        emits_left_next    = emits_left_reg;
        row_end_next       = row_end_reg;
        pending_code_next  = pending_code_reg;
        pending_valid_next = pending_valid_reg;
        for (int k = 0; k < cace_pkg::SlotCount; k++)
        begin
            codes_next[k] = codes_reg[k];
        end

        if (pair_fire)
        begin
            for (int k = 0; k < cace_pkg::SlotCount - 1; k++)
            begin
                codes_next[k] = codes_reg[k+1];
            end
            codes_next[cace_pkg::SlotCount-1] = cace_pkg::CodeBlack;
            ncodes_next     = ncodes_reg - 3'd1;
            emits_left_next = emits_left_reg - 3'd1;
            if (final_pair)
            begin
                busy_next = 1'b0;
            end
        end

        if (accept)
        begin
            busy_next    = 1'b1;
            row_end_next = in_ch.row_end;
            if (pending_valid_reg)
            begin
                codes_next[0] = pending_code_reg;
                for (int k = 0; k < 4; k++)
                begin
                    codes_next[k+1] = new_codes[k];
                end
                ncodes_next = 3'd5;
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                begin
                    codes_next[k] = new_codes[k];
                end
                codes_next[cace_pkg::SlotCount-1] = cace_pkg::CodeBlack;
                ncodes_next = 3'd4;
            end
            // Hold the last pair back unless the row ends here
            emits_left_next = in_ch.row_end ? ncodes_next : ncodes_next - 3'd1;
            if (in_ch.row_end)
            begin
                pending_valid_next = 1'b0;
                pending_code_next  = cace_pkg::CodeBlack;
            end
            else
            begin
                pending_valid_next = 1'b1;
                pending_code_next  = new_codes[3];
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            ncodes_reg        <= 3'd0;
            emits_left_reg    <= 3'd0;
            row_end_reg       <= 1'b0;
            pending_code_reg  <= cace_pkg::CodeBlack;
            pending_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg          <= busy_next;
            ncodes_reg        <= ncodes_next;
            emits_left_reg    <= emits_left_next;
            row_end_reg       <= row_end_next;
            pending_code_reg  <= pending_code_next;
            pending_valid_reg <= pending_valid_next;
        end
    end

    // Code queue payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < cace_pkg::SlotCount; k++)
        begin
            codes_reg[k] <= codes_next[k];
        end
    end

    // A byte taken while busy must coincide with the final pair leaving
    a_accept_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && busy_reg) |-> (pair_fire && final_pair))
        else $error("byte accepted before the previous byte finished");

    // Pairs still to issue never exceed the codes queued
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (emits_left_reg != 3'd0 && emits_left_reg <= ncodes_reg))
        else $error("issue count out of range");

    // A row end leaves no held pair behind
    a_row_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.row_end) |=> !pending_valid_reg)
        else $error("held pair survived a row end");

endmodule

FILE: rtl/core/cace_pixel_stage.sv
// Pixel stage: colours one pair, applies the artifact rule, holds the result register.
module cace_pixel_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_write_data,
    input  logic               pair_valid,
    output logic               pair_ready,
    input  cace_pkg::pair_t    pair,
    cace_out_if.source         out_ch
);

    logic                             palette_swap_reg;
    cace_pkg::pair_code_t             left_code_reg, left_code_next;
    logic                             left_valid_reg, left_valid_next;
    logic                             out_valid_reg, out_valid_next;
    logic [cace_pkg::PixelWidth-1:0]  left_pixel_reg, right_pixel_reg;
    logic                             row_done_reg, last_reg;
    logic [cace_pkg::PixelWidth-1:0]  base_color;
    logic [cace_pkg::PixelWidth-1:0]  left_pixel_next, right_pixel_next;
    logic                             load;

    assign pair_ready = !out_valid_reg || out_ch.ready;
    assign load       = pair_valid && pair_ready;

    // Look up the plain colour of the code
    always_comb
    begin
        case (pair.code)
            cace_pkg::CodeBlack:  base_color = cace_pkg::ColorBlack;
            cace_pkg::CodeBlue:   base_color = palette_swap_reg ? cace_pkg::ColorOrange
                                                                : cace_pkg::ColorBlue;
            cace_pkg::CodeOrange: base_color = palette_swap_reg ? cace_pkg::ColorBlue
                                                                : cace_pkg::ColorOrange;
            cace_pkg::CodeWhite:  base_color = cace_pkg::ColorWhite;
            default:              base_color = cace_pkg::ColorBlack;
        endcase
    end

    // Apply the artifact rule on the original codes
    always_comb
    begin
        left_pixel_next  = base_color;
        right_pixel_next = base_color;
        if (pair.code == cace_pkg::CodeBlue && pair.has_right &&
            (pair.right_code == cace_pkg::CodeOrange ||
             pair.right_code == cace_pkg::CodeWhite))
        begin
            left_pixel_next  = cace_pkg::ColorBlack;
            right_pixel_next = cace_pkg::ColorWhite;
        end
        else if (pair.code == cace_pkg::CodeOrange && left_valid_reg &&
                 (left_code_reg == cace_pkg::CodeBlue ||
                  left_code_reg == cace_pkg::CodeWhite))
        begin
            left_pixel_next  = cace_pkg::ColorWhite;
            right_pixel_next = cace_pkg::ColorBlack;
        end
    end

    // Track the left neighbour; drop it at the end of a row
    always_comb
    begin
        left_code_next  = left_code_reg;
        left_valid_next = left_valid_reg;
        if (load)
        begin
            if (pair.row_done)
            begin
                left_code_next  = cace_pkg::CodeBlack;
                left_valid_next = 1'b0;
            end
            else
            begin
                left_code_next  = pair.code;
                left_valid_next = 1'b1;
            end
        end
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_swap_reg <= 1'b0;
            left_code_reg    <= cace_pkg::CodeBlack;
            left_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                palette_swap_reg <= cfg_write_data;
            end
            left_code_reg  <= left_code_next;
            left_valid_reg <= left_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            left_pixel_reg  <= left_pixel_next;
            right_pixel_reg <= right_pixel_next;
            row_done_reg    <= pair.row_done;
            last_reg        <= pair.last;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.left_pixel  = left_pixel_reg;
    assign out_ch.right_pixel = right_pixel_reg;
    assign out_ch.row_done    = row_done_reg;
    assign out_ch.last        = last_reg;

endmodule

FILE: verif/crt_artifact_color_expander_tb.sv
// Self-checking testbench for the artifact colour expander: predicts pixel pairs per byte.
`timescale 1ns / 100ps

module crt_artifact_color_expander_tb;

    import cace_pkg::*;

    localparam int SettleCycles = 6;
    localparam int LongHoldOff  = 60;

    // Directed bytes as {row_end, source_byte}, palette at its reset value.
    // Single-byte rows of solid black and white, runs of one code, blue before
    // orange and white inside a byte, orange after blue and white, blue as the
    // last pair of a row, orange as the first pair of a row, and a blue pair
    // held back across a byte boundary ahead of an orange one.
    localparam logic [8:0] PlainPaletteItems [15] = '{
        9'h100, 9'h1FF, 9'h055, 9'h0AA, 9'h166, 9'h099, 9'h19D, 9'h081,
        9'h1B4, 9'h0E4, 9'h127, 9'h15A, 9'h1A5, 9'h03C, 9'h1C3
    };
    // Same rules again with blue and orange exchanged
    localparam logic [8:0] SwappedPaletteItems [6] = '{
        9'h11B, 9'h066, 9'h199, 9'h0FF, 9'h100, 9'h0E4
    };

    typedef struct packed {
        logic [PixelWidth-1:0] left_px;
        logic [PixelWidth-1:0] right_px;
        logic                  row_done;
        logic                  last;
    } pixel_pair_t;

    // Predict the pixel pairs of each source byte and check them in order
    class artifact_pixel_checker;
        logic        palette_swap;
        pair_code_t  held_code;
        logic        held_valid;
        pair_code_t  left_code;
        logic        left_valid;
        pixel_pair_t expected_pairs[$];
        int          mismatches;
        int          pairs_checked;

        function new();
            palette_swap  = 1'b0;
            held_code     = CodeBlack;
            held_valid    = 1'b0;
            left_code     = CodeBlack;
            left_valid    = 1'b0;
            mismatches    = 0;
            pairs_checked = 0;
        endfunction

        function logic [PixelWidth-1:0] plain_color(pair_code_t code);
            case (code)
                CodeBlue:   return palette_swap ? ColorOrange : ColorBlue;
                CodeOrange: return palette_swap ? ColorBlue : ColorOrange;
                CodeWhite:  return ColorWhite;
                default:    return ColorBlack;
            endcase
        endfunction

        function void note_source_byte(logic [7:0] source_byte, logic row_end);
            pair_code_t            codes [SlotCount];
            pair_code_t            right;
            logic                  has_right;
            logic [PixelWidth-1:0] lp;
            logic [PixelWidth-1:0] rp;
            pixel_pair_t           pair;
            int                    n;
            int                    emit;
            n = 0;
            if (held_valid)
            begin
                codes[n] = held_code;
                n++;
            end
            for (int i = 0; i < 4; i++)
            begin
                codes[n] = pair_code_t'(source_byte[7-2*i -: 2]);
                n++;
            end
            // Hold the final pair back unless the row ends here
            emit = row_end ? n : n - 1;
            for (int i = 0; i < emit; i++)
            begin
                has_right = (i + 1) < n;
                right     = has_right ? codes[i+1] : CodeBlack;
                lp        = plain_color(codes[i]);
                rp        = lp;
                if (codes[i] == CodeBlue && has_right &&
                    (right == CodeOrange || right == CodeWhite))
                begin
                    lp = ColorBlack;
                    rp = ColorWhite;
                end
                else if (codes[i] == CodeOrange && left_valid &&
                         (left_code == CodeBlue || left_code == CodeWhite))
                begin
                    lp = ColorWhite;
                    rp = ColorBlack;
                end
                pair.left_px  = lp;
                pair.right_px = rp;
                pair.row_done = row_end && (i == n - 1);
                pair.last     = (i == emit - 1);
                expected_pairs.push_back(pair);
                left_code  = codes[i];
                left_valid = 1'b1;
            end
            // Clear the row context at a row end, else keep the last pair
            if (row_end)
            begin
                held_valid = 1'b0;
                held_code  = CodeBlack;
                left_valid = 1'b0;
                left_code  = CodeBlack;
            end
            else
            begin
                held_code  = codes[n-1];
                held_valid = 1'b1;
            end
        endfunction

        function void check_pixel_pair(pixel_pair_t got);
            pixel_pair_t want;
            if (expected_pairs.size() == 0)
            begin
                $display("%0t: pixel pair with nothing expected: left %h right %h done %b last %b",
                         $time, got.left_px, got.right_px, got.row_done, got.last);
                mismatches++;
                return;
            end
            want = expected_pairs.pop_front();
            pairs_checked++;
            if (got.left_px !== want.left_px)
            begin
                $display("%0t: left_pixel expected %h actual %h", $time, want.left_px, got.left_px);
                mismatches++;
            end
            if (got.right_px !== want.right_px)
            begin
                $display("%0t: right_pixel expected %h actual %h", $time, want.right_px,
                         got.right_px);
                mismatches++;
            end
            if (got.row_done !== want.row_done)
            begin
                $display("%0t: row_done expected %b actual %b", $time, want.row_done, got.row_done);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return expected_pairs.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;
    bit   rx_idling;
    bit   hold_off_req;
    int   bytes_sent;
    int   palette_writes;

    artifact_pixel_checker pixel_checker;

    cace_in_if  in_ch ();
    cace_out_if out_ch ();

    crt_artifact_color_expander i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_ch          (in_ch),
        .out_ch         (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 2);
        else if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(10, 40);
    endfunction

    // Favour coloured codes so the artifact rules fire often
    function automatic logic [7:0] pick_source_byte();
        logic [7:0] source_byte;
        pair_code_t code;
        source_byte = 8'($urandom);
        if ($urandom_range(0, 1) == 0)
        begin
            for (int i = 0; i < 4; i++)
            begin
                code = ($urandom_range(0, 4) == 0) ? CodeBlack
                                                   : pair_code_t'($urandom_range(1, 3));
                source_byte[7-2*i -: 2] = code;
            end
        end
        return source_byte;
    endfunction

    // Offer one byte, hold it until the transfer, then maybe idle
    task automatic send_byte(input logic [7:0] source_byte, input logic row_end,
                             input bit with_gaps);
        in_ch.valid       <= 1'b1;
        in_ch.source_byte <= source_byte;
        in_ch.row_end     <= row_end;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        pixel_checker.note_source_byte(source_byte, row_end);
        bytes_sent++;
        if (with_gaps && $urandom_range(0, 99) < 30)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.source_byte <= 8'($urandom);
            in_ch.row_end     <= 1'($urandom);
            repeat (pick_gap()) @(posedge clk);
        end
    endtask

    // Send random rows, mostly short, occasionally long
    task automatic send_rows(input int count, input bit with_gaps);
        int row_left;
        row_left = 0;
        for (int k = 0; k < count; k++)
        begin
            if (row_left == 0)
                row_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                      : $urandom_range(1, 4);
            send_byte(pick_source_byte(), row_left == 1, with_gaps);
            row_left--;
        end
    endtask

    // Pause the input until every expected pair has arrived
    task automatic wait_drained(input int settle);
        in_ch.valid <= 1'b0;
        while (pixel_checker.outstanding() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_palette(input logic swap);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= swap;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        pixel_checker.palette_swap = swap;
        palette_writes++;
    endtask

    // Receiver: random stalls when idling, one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LongHoldOff) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (rx_idling && $urandom_range(0, 99) < 25)
            begin
                out_ch.ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Check every pair transfer against the oldest prediction
    always @(posedge clk)
    begin
        pixel_pair_t got;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            got.left_px  = out_ch.left_pixel;
            got.right_px = out_ch.right_pixel;
            got.row_done = out_ch.row_done;
            got.last     = out_ch.last;
            pixel_checker.check_pixel_pair(got);
        end
    end

    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        in_ch.valid       <= 1'b0;
        in_ch.source_byte <= 8'h00;
        in_ch.row_end     <= 1'b0;
        cfg_write_en      <= 1'b0;
        cfg_write_data    <= 1'b0;
        rst_n             <= 1'b0;
        rx_idling      = 1'b0;
        hold_off_req   = 1'b0;
        bytes_sent     = 0;
        palette_writes = 0;
        pixel_checker  = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases, first with the reset palette then swapped
        foreach (PlainPaletteItems[k])
            send_byte(PlainPaletteItems[k][7:0], PlainPaletteItems[k][8], 1'b0);
        wait_drained(SettleCycles);
        write_palette(1'b1);
        foreach (SwappedPaletteItems[k])
            send_byte(SwappedPaletteItems[k][7:0], SwappedPaletteItems[k][8], 1'b0);
        wait_drained(SettleCycles);

        // Random rows at full rate
        write_palette(1'b0);
        send_rows(30, 1'b0);
        wait_drained(SettleCycles);

        // Random rows with gaps on both sides
        write_palette(1'b1);
        rx_idling = 1'b1;
        send_rows(40, 1'b1);
        wait_drained(SettleCycles);

        // Long receiver hold-off while the sender keeps offering bytes
        rx_idling    = 1'b0;
        hold_off_req = 1'b1;
        send_rows(20, 1'b0);
        wait_drained(SettleCycles);

        write_palette(1'b0);
        rx_idling = 1'b1;
        send_rows(40, 1'b1);
        wait_drained(SettleCycles);

        write_palette(1'b1);
        rx_idling = 1'b0;
        send_rows(20, 1'b1);
        wait_drained(SettleCycles);

        $display("Sent %0d source bytes, checked %0d pixel pairs, %0d palette writes.",
                 bytes_sent, pixel_checker.pairs_checked, palette_writes);
        $display("Ran directed artifact cases, random rows, gaps and a %0d-cycle output hold-off.",
                 LongHoldOff);
        if (pixel_checker.mismatches == 0 && pixel_checker.outstanding() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cace_pkg.sv
rtl/core/cace_in_if.sv
rtl/core/cace_out_if.sv
rtl/core/cace_item_stage.sv
rtl/core/cace_pixel_stage.sv
rtl/core/crt_artifact_color_expander.sv
verif/crt_artifact_color_expander_tb.sv
